// File: hw/rtl/msixvt_pkg.sv
// Shared types and constants for the MSI-X vector table controller.
`timescale 1ns / 1ps

package msixvt_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_FMASK = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_TABLE_OFFSET = 2'd0,
    CFG_PBA_OFFSET   = 2'd1,
    CFG_NUM_VECTORS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCAN,
    ST_MSG_RD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] BAD_READ    = 32'hdeadf00d;
  localparam logic [1:0]  CTRL_WORD   = 2'd3;
  localparam logic [1:0]  WORD_ADDR_LO = 2'd0;
  localparam logic [1:0]  WORD_ADDR_HI = 2'd1;
  localparam logic [1:0]  WORD_DATA    = 2'd2;
  localparam int          ENTRY_BYTES = 16;
  localparam int          PBA_BYTES   = 4;
  localparam int          CFG_W       = 12;
  localparam int          NUMV_W      = 6;
  localparam int          VEC_FIELD_W = 5;

  typedef struct packed {
    logic in_tbl;
    logic in_pba;
  } region_t;

  typedef struct packed {
    logic [31:0]            read_data;
    logic                   msg_valid;
    logic [63:0]            msg_address;
    logic [31:0]            msg_data;
    logic [VEC_FIELD_W-1:0] msg_vector;
    logic                   last;
  } result_t;

endpackage

// File: hw/rtl/msixvt_decode.sv
// Host offset decode into table and PBA regions, and table dword index.
`timescale 1ns / 1ps

module msixvt_decode import msixvt_pkg::*; #(
  parameter int MAX_VECTORS  = 32,
  parameter int REGION_BYTES = 4096,
  parameter int ADDR_W       = 7
) (
  input  logic [CFG_W-1:0]  offset,
  input  logic [CFG_W-1:0]  table_offset,
  input  logic [CFG_W-1:0]  pba_offset,
  output region_t           region,
  output logic [ADDR_W-1:0] dw_addr
);

  localparam int SPAN_W = CFG_W + 1;

  logic [SPAN_W-1:0] off_x;
  logic [SPAN_W-1:0] tbl_x;
  logic [SPAN_W-1:0] pba_x;
  logic [SPAN_W-1:0] tbl_end;
  logic [SPAN_W-1:0] pba_end;
  logic [CFG_W-1:0]  diff;
  logic              in_space;

  assign off_x    = {1'b0, offset};
  assign tbl_x    = {1'b0, table_offset};
  assign pba_x    = {1'b0, pba_offset};
  assign tbl_end  = tbl_x + SPAN_W'(ENTRY_BYTES * MAX_VECTORS);
  assign pba_end  = pba_x + SPAN_W'(PBA_BYTES);
  assign in_space = off_x < SPAN_W'(REGION_BYTES);

  // lower region is cut short where the other one begins
  assign region.in_tbl = in_space && (off_x >= tbl_x) && (off_x < tbl_end) &&
                         !((tbl_x < pba_x) && (off_x >= pba_x));
  assign region.in_pba = in_space && (off_x >= pba_x) && (off_x < pba_end) &&
                         !((pba_x < tbl_x) && (off_x >= tbl_x));

  assign diff    = offset - table_offset;
  assign dw_addr = diff[ADDR_W+1:2];

endmodule

// File: hw/rtl/msixvt_ram.sv
// Vector table dword memory with per-dword valid bits standing in for reset.
`timescale 1ns / 1ps

module msixvt_ram #(
  parameter int MAX_VECTORS = 32,
  parameter int ADDR_W      = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [31:0]       rdata
);

  localparam int DEPTH = MAX_VECTORS * 4;

  logic [31:0] mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;
  logic [31:0] rd_q;
  logic        rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (we) begin
        entry_valid[waddr] <= 1'b1;
      end
      rd_valid <= entry_valid[raddr];
    end
  end

  // never-written dwords read as zero
  assign rdata = rd_valid ? rd_q : 32'd0;

endmodule

// File: hw/rtl/msixvt_seq.sv
// Transaction sequencer: masks, pending bits, flush walk and message assembly.
`timescale 1ns / 1ps

module msixvt_seq import msixvt_pkg::*; #(
  parameter int MAX_VECTORS = 32,
  parameter int VEC_W       = 5,
  parameter int ADDR_W      = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [31:0]       write_data,
  input  logic [4:0]        vector,
  input  logic              mask_value,
  input  region_t           region,
  input  logic [ADDR_W-1:0] dw_addr,
  input  logic [NUMV_W-1:0] num_vectors,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [31:0]       ram_rdata,
  output logic              emit_valid,
  input  logic              emit_ready,
  output result_t           res
);

  state_t state;
  state_t state_next;

  action_t              act;
  region_t              reg_hit;
  logic [VEC_W-1:0]     acc_vec;
  logic [1:0]           acc_word;
  logic [31:0]          wdata;
  logic [4:0]           rvec;
  logic                 mval;
  logic                 fmasked;
  logic [MAX_VECTORS-1:0] vmask;
  logic [MAX_VECTORS-1:0] pending;
  logic [MAX_VECTORS-1:0] scan;
  logic [MAX_VECTORS-1:0] in_range;
  logic [MAX_VECTORS-1:0] cur_bit;
  logic [VEC_W-1:0]     cur;
  logic [1:0]           cnt;

  logic accept;
  logic is_ctrl;
  logic vec_ok;
  logic [VEC_W-1:0] rv;
  logic unmask_send;
  logic raise_send;
  logic raise_hold;
  logic flush_start;
  logic read_mem;
  logic scan_empty;
  logic flush_last;

  assign accept      = in_valid && in_ready;
  assign is_ctrl     = acc_word == CTRL_WORD;
  assign vec_ok      = {1'b0, rvec} < 6'(MAX_VECTORS);
  assign rv          = rvec[VEC_W-1:0];
  assign unmask_send = (act == ACT_WRITE) && reg_hit.in_tbl && is_ctrl && !wdata[0] &&
                       pending[acc_vec] && !fmasked;
  assign raise_send  = (act == ACT_RAISE) && vec_ok && !fmasked && !vmask[rv];
  assign raise_hold  = (act == ACT_RAISE) && vec_ok && (fmasked || vmask[rv]);
  assign flush_start = (act == ACT_FMASK) && fmasked && !mval;
  assign read_mem    = (act == ACT_READ) && reg_hit.in_tbl && !is_ctrl;

  always_comb begin
    for (int i = 0; i < MAX_VECTORS; i++) begin
      in_range[i] = NUMV_W'(i) < num_vectors;
    end
  end

  assign cur_bit    = MAX_VECTORS'(1) << cur;
  assign scan_empty = scan == '0;
  assign flush_last = (scan & ~cur_bit) == '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (read_mem) state_next = ST_RD_WAIT;
        else if (unmask_send || raise_send) state_next = ST_MSG_RD;
        else if (flush_start) state_next = ST_SCAN;
        else state_next = ST_EMIT;
      end
      ST_RD_WAIT: state_next = ST_EMIT;
      ST_SCAN: begin
        if (scan_empty) state_next = ST_EMIT;
        else if (scan[cur]) state_next = ST_MSG_RD;
      end
      ST_MSG_RD: begin
        if (cnt == CTRL_WORD) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ready) state_next = res.last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    emit_valid = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = {acc_vec, acc_word};
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_EXEC:   ram_we = (act == ACT_WRITE) && reg_hit.in_tbl && !is_ctrl;
      ST_MSG_RD: ram_raddr = {cur, cnt};
      ST_EMIT:   emit_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign ram_waddr = {acc_vec, acc_word};
  assign ram_wdata = wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fmasked <= 1'b0;
      vmask   <= '1;
      pending <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC) begin
        if ((act == ACT_WRITE) && reg_hit.in_tbl && is_ctrl) begin
          vmask[acc_vec] <= wdata[0];
        end
        if (unmask_send) begin
          pending[acc_vec] <= 1'b0;
        end
        if (raise_hold) begin
          pending[rv] <= 1'b1;
        end
        if (act == ACT_FMASK) begin
          fmasked <= mval;
        end
      end
      if ((state == ST_SCAN) && !scan_empty && scan[cur]) begin
        pending[cur] <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action_t'(action);
      reg_hit  <= region;
      acc_vec  <= dw_addr[ADDR_W-1:2];
      acc_word <= dw_addr[1:0];
      wdata    <= write_data;
      rvec     <= vector;
      mval     <= mask_value;
    end
    unique case (state)
      ST_EXEC: begin
        res      <= '0;
        res.last <= 1'b1;
        cnt      <= WORD_ADDR_LO;
        if (act == ACT_READ) begin
          if (reg_hit.in_tbl) res.read_data <= {31'd0, vmask[acc_vec]};
          else if (reg_hit.in_pba) res.read_data <= 32'(pending);
          else res.read_data <= BAD_READ;
        end
        if (unmask_send) begin
          cur            <= acc_vec;
          res.msg_valid  <= 1'b1;
          res.msg_vector <= VEC_FIELD_W'(acc_vec);
        end
        if (raise_send) begin
          cur            <= rv;
          res.msg_valid  <= 1'b1;
          res.msg_vector <= VEC_FIELD_W'(rv);
        end
        if (flush_start) begin
          scan <= pending & in_range;
          cur  <= '0;
        end
      end
      ST_RD_WAIT: res.read_data <= ram_rdata;
      ST_SCAN: begin
        res      <= '0;
        res.last <= 1'b1;
        cnt      <= WORD_ADDR_LO;
        if (!scan_empty) begin
          if (scan[cur]) begin
            scan[cur]      <= 1'b0;
            res.msg_valid  <= 1'b1;
            res.msg_vector <= VEC_FIELD_W'(cur);
            res.last       <= flush_last;
          end else begin
            cur <= cur + 1'b1;
          end
        end
      end
      ST_MSG_RD: begin
        cnt <= cnt + 1'b1;
        // read data is the word issued in the previous cycle (registered memory read)
        case (cnt)
          WORD_ADDR_HI: res.msg_address[31:0]  <= ram_rdata;
          WORD_DATA:    res.msg_address[63:32] <= ram_rdata;
          CTRL_WORD:    res.msg_data           <= ram_rdata;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/msix_vector_table_controller_unit.sv
// MSI-X vector table controller top level: config registers and result register.
// A host read of a table address or data dword goes through the table memory;
// a message reads its table entry word by word through the memory's single read port.
// Mask-clear flush: vectors are scanned in order and each pending one sends a message.
// One transaction at a time: no new input is taken until its last result is emitted.
// Reset: synchronous; vectors masked, nothing pending, function unmasked.
`timescale 1ns / 1ps

module msix_vector_table_controller_unit import msixvt_pkg::*; #(
  parameter int MAX_VECTORS  = 32,
  parameter int REGION_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [CFG_W-1:0]       offset,
  input  logic [31:0]            write_data,
  input  logic [4:0]             vector,
  input  logic                   mask_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            read_data,
  output logic                   msg_valid,
  output logic [63:0]            msg_address,
  output logic [31:0]            msg_data,
  output logic [VEC_FIELD_W-1:0] msg_vector,
  output logic                   last
);

  localparam int VEC_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int ADDR_W = VEC_W + 2;

  logic [CFG_W-1:0]  table_offset;
  logic [CFG_W-1:0]  pba_offset;
  logic [NUMV_W-1:0] num_vectors;

  region_t           region;
  logic [ADDR_W-1:0] dw_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic              emit_valid;
  logic              emit_ready;
  result_t           res;
  result_t           out_res;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_offset <= CFG_W'(0);
      pba_offset   <= CFG_W'(2048);
      num_vectors  <= NUMV_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TABLE_OFFSET: table_offset <= cfg_data;
        CFG_PBA_OFFSET:   pba_offset   <= cfg_data;
        CFG_NUM_VECTORS:  num_vectors  <= cfg_data[NUMV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msixvt_decode #(
    .MAX_VECTORS  (MAX_VECTORS),
    .REGION_BYTES (REGION_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_decode (
    .offset       (offset),
    .table_offset (table_offset),
    .pba_offset   (pba_offset),
    .region       (region),
    .dw_addr      (dw_addr)
  );

  msixvt_ram #(
    .MAX_VECTORS (MAX_VECTORS),
    .ADDR_W      (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msixvt_seq #(
    .MAX_VECTORS (MAX_VECTORS),
    .VEC_W       (VEC_W),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .write_data  (write_data),
    .vector      (vector),
    .mask_value  (mask_value),
    .region      (region),
    .dw_addr     (dw_addr),
    .num_vectors (num_vectors),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .emit_valid  (emit_valid),
    .emit_ready  (emit_ready),
    .res         (res)
  );

  // result register decouples the sequencer from the consumer
  assign emit_ready = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (emit_valid && emit_ready) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_res <= res;
    end
  end

  assign read_data   = out_res.read_data;
  assign msg_valid   = out_res.msg_valid;
  assign msg_address = out_res.msg_address;
  assign msg_data    = out_res.msg_data;
  assign msg_vector  = out_res.msg_vector;
  assign last        = out_res.last;

  // no new transaction while a result is still being produced
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && emit_valid))
    else $error("input taken while a result is in flight");

  a_msg_vector_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_valid) |-> ({1'b0, msg_vector} < 6'(MAX_VECTORS)) &&
                                 (read_data == 32'd0))
    else $error("message result out of range or carrying read data");

  a_no_msg_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !msg_valid) |-> (msg_address == 64'd0) && (msg_data == 32'd0) &&
                                  (msg_vector == '0))
    else $error("message fields set on a result without a message");

endmodule

// File: tb/msixvt_checker.sv
// Checker for the MSI-X vector table controller: shadow state, expected results, comparison.
`timescale 1ns / 1ps

module msixvt_checker import msixvt_pkg::*; #(
  parameter int MAX_VECTORS  = 32,
  parameter int REGION_BYTES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             action,
  input  logic [CFG_W-1:0]       offset,
  input  logic [31:0]            write_data,
  input  logic [4:0]             vector,
  input  logic                   mask_value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [31:0]            read_data,
  input  logic                   msg_valid,
  input  logic [63:0]            msg_address,
  input  logic [31:0]            msg_data,
  input  logic [VEC_FIELD_W-1:0] msg_vector,
  input  logic                   last,
  output int                     open_count,
  output int                     fail_count
);

  localparam int TABLE_WORDS      = MAX_VECTORS * 4;
  localparam int PBA_OFFSET_RESET = 2048;

  logic [31:0] entry_words [TABLE_WORDS];
  logic [31:0] pend_bits;
  logic        fn_masked;
  int          tbl_base;
  int          pba_base;
  int          scan_count;
  result_t     due_results [$];

  function automatic bit hits_table(int off);
    if (off >= REGION_BYTES || off < tbl_base) return 1'b0;
    if (off >= tbl_base + ENTRY_BYTES * MAX_VECTORS) return 1'b0;
    // overlapping regions: the lower one stops where the other starts
    if (tbl_base < pba_base && off >= pba_base) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit hits_pba(int off);
    if (off >= REGION_BYTES || off < pba_base) return 1'b0;
    if (off >= pba_base + PBA_BYTES) return 1'b0;
    if (pba_base < tbl_base && off >= tbl_base) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int word_index(int off);
    return ((off - tbl_base) >> 2) % TABLE_WORDS;
  endfunction

  task automatic queue_message(int v);
    result_t r;
    r = '0;
    r.msg_valid   = 1'b1;
    r.msg_address = {entry_words[v * 4 + int'(WORD_ADDR_HI)],
                     entry_words[v * 4 + int'(WORD_ADDR_LO)]};
    r.msg_data    = entry_words[v * 4 + int'(WORD_DATA)];
    r.msg_vector  = VEC_FIELD_W'(v);
    due_results.push_back(r);
  endtask

  task automatic predict_transaction(action_t act, int off, logic [31:0] wd, int vec,
                                     logic mv);
    result_t r;
    int      n_before;
    int      dw;
    int      v;
    int      lim;
    logic    was_masked;
    n_before = due_results.size();
    case (act)
      ACT_READ: begin
        r = '0;
        r.read_data = BAD_READ;
        if (hits_table(off)) r.read_data = entry_words[word_index(off)];
        else if (hits_pba(off)) r.read_data = pend_bits;
        due_results.push_back(r);
      end
      ACT_WRITE: begin
        if (hits_table(off)) begin
          dw = word_index(off);
          if (dw % 4 == int'(CTRL_WORD)) begin
            v  = dw / 4;
            wd = {31'd0, wd[0]};
            // unmasking a pending vector only fires while the function is unmasked
            if (!wd[0] && pend_bits[v] && !fn_masked) begin
              queue_message(v);
              pend_bits[v] = 1'b0;
            end
          end
          entry_words[dw] = wd;
        end
      end
      ACT_RAISE: begin
        if (vec < MAX_VECTORS) begin
          if (fn_masked || entry_words[vec * 4 + int'(CTRL_WORD)][0]) pend_bits[vec] = 1'b1;
          else queue_message(vec);
        end
      end
      default: begin
        was_masked = fn_masked;
        fn_masked  = mv;
        if (was_masked && !mv) begin
          lim = (scan_count > MAX_VECTORS) ? MAX_VECTORS : scan_count;
          for (v = 0; v < lim; v++) begin
            if (pend_bits[v]) begin
              queue_message(v);
              pend_bits[v] = 1'b0;
            end
          end
        end
      end
    endcase
    // no message: one empty result; either way the final one carries last
    r = '0;
    if (due_results.size() != n_before) r = due_results.pop_back();
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(result_t want);
    if (read_data !== want.read_data)
      report_mismatch("read_data", 64'(read_data), 64'(want.read_data));
    if (msg_valid !== want.msg_valid)
      report_mismatch("msg_valid", 64'(msg_valid), 64'(want.msg_valid));
    if (msg_address !== want.msg_address)
      report_mismatch("msg_address", msg_address, want.msg_address);
    if (msg_data !== want.msg_data)
      report_mismatch("msg_data", 64'(msg_data), 64'(want.msg_data));
    if (msg_vector !== want.msg_vector)
      report_mismatch("msg_vector", 64'(msg_vector), 64'(want.msg_vector));
    if (last !== want.last)
      report_mismatch("last", 64'(last), 64'(want.last));
  endtask

  always @(posedge clk) begin : track
    int i;
    if (rst) begin
      for (i = 0; i < TABLE_WORDS; i++)
        entry_words[i] = (i % 4 == int'(CTRL_WORD)) ? 32'd1 : 32'd0;
      pend_bits  = '0;
      fn_masked  = 1'b0;
      tbl_base   = 0;
      pba_base   = PBA_OFFSET_RESET;
      scan_count = MAX_VECTORS;
      due_results.delete();
      fail_count = 0;
      open_count <= 0;
    end else begin
      // results first: one accepted now belongs to an earlier transaction
      if (out_valid && out_ready) begin
        if (due_results.size() == 0)
          report_mismatch("unexpected result, read_data", 64'(read_data), 64'd0);
        else
          check_result(due_results.pop_front());
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_TABLE_OFFSET: tbl_base   = int'(cfg_data);
          CFG_PBA_OFFSET:   pba_base   = int'(cfg_data);
          CFG_NUM_VECTORS:  scan_count = int'(cfg_data[NUMV_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_transaction(action_t'(action), int'(offset), write_data, int'(vector),
                            mask_value);
      open_count <= due_results.size();
    end
  end

endmodule

// File: tb/msix_vector_table_controller_unit_tb.sv
// Testbench top for the MSI-X vector table controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module msix_vector_table_controller_unit_tb;
  import msixvt_pkg::*;

  localparam int MAX_VECTORS     = 32;
  localparam int REGION_BYTES    = 4096;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_we     = 1'b0;
  logic [1:0]             cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [1:0]             action     = '0;
  logic [CFG_W-1:0]       offset     = '0;
  logic [31:0]            write_data = '0;
  logic [4:0]             vector     = '0;
  logic                   mask_value = 1'b0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [31:0]            read_data;
  logic                   msg_valid;
  logic [63:0]            msg_address;
  logic [31:0]            msg_data;
  logic [VEC_FIELD_W-1:0] msg_vector;
  logic                   last;

  int open_count;
  int fail_count;
  int cycle_count = 0;
  int tb_tbl      = 0;
  int tb_pba      = 2048;
  int in_calm     = 0;
  int out_calm    = 0;
  int out_wait    = 0;

  // table offset, PBA offset and scan count for each phase after the reset setting
  int phase_tbl [NUM_PHASES] = '{0, 4095, 256, 258, 3584, 2000};
  int phase_pba [NUM_PHASES] = '{4092, 0, 320, 256, 1024, 4095};
  int phase_nv  [NUM_PHASES] = '{1, 0, 63, 17, 32, 40};

  msix_vector_table_controller_unit #(
    .MAX_VECTORS (MAX_VECTORS),
    .REGION_BYTES(REGION_BYTES)
  ) dut (.*);

  msixvt_checker #(
    .MAX_VECTORS (MAX_VECTORS),
    .REGION_BYTES(REGION_BYTES)
  ) checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("msix_vector_table_controller_unit regression: fail");
      $finish;
    end
  end

  // idle cycles before a transaction; now and then a run with none at all
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  always @(posedge clk) begin : out_pacing
    int pause;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        pause = draw_gap(out_calm);
        if (pause > 0) begin
          out_ready <= 1'b0;
          out_wait  <= pause - 1;
        end
      end
    end else if (out_wait == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_wait <= out_wait - 1;
    end
  end

  task automatic present(action_t act, int off, logic [31:0] wd, int vec, logic mv);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    offset     <= CFG_W'(off);
    write_data <= wd;
    vector     <= 5'(vec);
    mask_value <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic configure(int tbl, int pba, int nv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TABLE_OFFSET;
    cfg_data  <= CFG_W'(tbl);
    @(posedge clk);
    cfg_index <= CFG_PBA_OFFSET;
    cfg_data  <= CFG_W'(pba);
    @(posedge clk);
    cfg_index <= CFG_NUM_VECTORS;
    cfg_data  <= CFG_W'(nv);
    @(posedge clk);
    cfg_we <= 1'b0;
    tb_tbl = tbl;
    tb_pba = pba;
  endtask

  task automatic random_item();
    int          pick;
    int          vec;
    int          word;
    int          off;
    logic [31:0] wd;
    logic        mv;
    pick = $urandom_range(0, 99);
    vec  = $urandom_range(0, 31);
    word = $urandom_range(0, 3);
    wd   = $urandom;
    mv   = 1'($urandom_range(0, 1));
    // mostly live table entries and the PBA, sometimes anywhere in the region
    case ($urandom_range(0, 7))
      0:       off = $urandom_range(0, 4095);
      1, 2:    off = tb_pba + $urandom_range(0, 3);
      default: off = tb_tbl + vec * ENTRY_BYTES + word * 4 + $urandom_range(0, 3);
    endcase
    off = off % REGION_BYTES;
    if (pick < 25) present(ACT_READ, off, wd, vec, mv);
    else if (pick < 55) present(ACT_WRITE, off, wd, vec, mv);
    else if (pick < 85) present(ACT_RAISE, off, wd, vec, mv);
    else present(ACT_FMASK, off, wd, vec, mv);
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset setting: table at 0, PBA at 2048, every vector masked
    present(ACT_READ,  'h000, 32'd0, 0, 1'b0);
    present(ACT_READ,  'h00c, 32'd0, 0, 1'b0);
    present(ACT_READ,  'h800, 32'd0, 0, 1'b0);
    present(ACT_READ,  'hfff, 32'd0, 31, 1'b1);
    present(ACT_WRITE, 'h050, 32'hffffffff, 0, 1'b0);
    present(ACT_WRITE, 'h054, 32'h12345678, 0, 1'b0);
    present(ACT_WRITE, 'h05a, 32'ha5a5a5a5, 0, 1'b0);
    present(ACT_READ,  'h058, 32'd0, 0, 1'b0);
    present(ACT_RAISE, 'h000, 32'd0, 5, 1'b0);        // masked vector goes pending
    present(ACT_READ,  'h803, 32'd0, 0, 1'b0);
    present(ACT_WRITE, 'h05c, 32'hfffffffe, 0, 1'b0); // unmask sends the pending one
    present(ACT_RAISE, 'h000, 32'd0, 5, 1'b0);
    present(ACT_RAISE, 'h000, 32'd0, 31, 1'b0);
    present(ACT_WRITE, 'h1fc, 32'hffffffff, 0, 1'b0); // only bit 0 kept
    present(ACT_READ,  'h1fc, 32'd0, 0, 1'b0);
    present(ACT_FMASK, 'h000, 32'd0, 0, 1'b1);
    present(ACT_RAISE, 'h000, 32'd0, 0, 1'b0);
    present(ACT_RAISE, 'h000, 32'd0, 5, 1'b0);
    present(ACT_WRITE, 'h05c, 32'd0, 0, 1'b0);        // function masked: stays pending
    present(ACT_FMASK, 'h000, 32'd0, 0, 1'b1);
    present(ACT_FMASK, 'h000, 32'd0, 0, 1'b0);        // flush 0, 5, 31
    present(ACT_FMASK, 'h000, 32'd0, 0, 1'b0);
    present(ACT_WRITE, 'hbb8, 32'hffffffff, 0, 1'b0); // outside the table, dropped
    present(ACT_RAISE, 'hfff, 32'hffffffff, 5, 1'b1);
    repeat (ITEMS_PER_PHASE) random_item();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      configure(phase_tbl[phase], phase_pba[phase], phase_nv[phase]);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("msix_vector_table_controller_unit regression: pass");
    end else begin
      $display("msix_vector_table_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/msixvt_pkg.sv
hw/rtl/msixvt_decode.sv
hw/rtl/msixvt_ram.sv
hw/rtl/msixvt_seq.sv
hw/rtl/msix_vector_table_controller_unit.sv
tb/msixvt_checker.sv
tb/msix_vector_table_controller_unit_tb.sv
